// File: rtl/pst_pkg.sv
// Shared types, sizes and helpers for the potentiometer soft-takeover block.
package pst_pkg;

    // Sizing
    localparam int CHANNELS   = 8;
    localparam int VALUE_BITS = 12;
    localparam int POT_MAX_W  = 12;
    localparam int OUT_W      = 12;
    localparam int CHAN_W     = 3;
    localparam int RAW_W      = 16;
    localparam int HOOK_W     = 12;
    localparam int WIDE_W     = 16;
    localparam int CH_EXT_W   = 7;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [POT_MAX_W-1:0] POT_MAX_RESET = 12'd4095;

    // Request codes
    localparam logic REQ_READING = 1'b0;
    localparam logic REQ_HOOK    = 1'b1;

    // Per-channel pickup state
    typedef enum logic [1:0] {
        HS_UNHOOKED = 2'd0,
        HS_HOOKING  = 2'd1,
        HS_UNDER    = 2'd2,
        HS_OVER     = 2'd3
    } hook_t;

    typedef struct packed {
        hook_t                 hook;
        logic [VALUE_BITS-1:0] held;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

    // Decoded transaction kind, captured at accept
    typedef struct packed {
        logic is_hook;
        logic ok;
        logic in_range;
    } pst_op_t;

    // Update unit verdict
    typedef struct packed {
        logic             wr_en;
        logic             has_result;
        entry_t           entry;
        logic [OUT_W-1:0] result;
    } pst_upd_t;

    // Fit a held value to the result width
    function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(v);
        return wide[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/pst_if.sv
// Valid/ready channel interfaces for requests and results.
interface pst_in_if import pst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAN_W-1:0] channel;
    logic [RAW_W-1:0]  raw_reading;
    logic              read_ok;
    logic [HOOK_W-1:0] hook_value;

    modport source (
        output valid, req_type, channel, raw_reading, read_ok, hook_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, raw_reading, read_ok, hook_value,
        output ready
    );
endinterface

interface pst_out_if import pst_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] pot_value;

    modport source (
        output valid, pot_value,
        input  ready
    );
    modport sink (
        input  valid, pot_value,
        output ready
    );
endinterface

// File: rtl/pst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pst_update.sv
// Pickup update: next channel entry and returned value for one transaction.
module pst_update import pst_pkg::*; (
    input  pst_op_t               op,
    input  entry_t                cur,
    input  logic [VALUE_BITS-1:0] live,
    input  logic [VALUE_BITS-1:0] hook,
    output pst_upd_t              upd
);

    entry_t nxt;

    // Step the hook state against the live value
    always_comb
    begin
        nxt = cur;
        unique case (cur.hook)
            HS_UNHOOKED:
            begin
                nxt.held = live;
            end
            HS_HOOKING:
            begin
                if (live < cur.held)
                begin
                    nxt.hook = HS_UNDER;
                end
                else if (live > cur.held)
                begin
                    nxt.hook = HS_OVER;
                end
                else
                begin
                    nxt.hook = HS_UNHOOKED;
                    nxt.held = live;
                end
            end
            HS_UNDER:
            begin
                if (live >= cur.held)
                begin
                    nxt.hook = HS_UNHOOKED;
                    nxt.held = live;
                end
            end
            HS_OVER:
            begin
                if (live <= cur.held)
                begin
                    nxt.hook = HS_UNHOOKED;
                    nxt.held = live;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Pick write-back and result by transaction kind
    always_comb
    begin
        upd.wr_en      = 1'b0;
        upd.has_result = 1'b1;
        upd.entry      = cur;
        upd.result     = to_out(cur.held);
        priority if (op.is_hook)
        begin
            upd.has_result = 1'b0;
            upd.wr_en      = op.in_range;
            upd.entry.hook = HS_HOOKING;
            upd.entry.held = hook;
        end
        else if (!op.in_range)
        begin
            upd.result = '0;
        end
        else if (op.ok)
        begin
            upd.wr_en  = 1'b1;
            upd.entry  = nxt;
            upd.result = to_out(nxt.held);
        end
        else
        begin
            upd.result = to_out(cur.held);
        end
    end

endmodule

// File: rtl/pot_soft_takeover_core.sv
// Potentiometer soft-takeover core: top level with state memory and sequencer.
//
// Each request passes through sequencer states S_IDLE and S_EXEC: acceptance
// issues the read of the channel's entry in the state memory, and the next
// cycle updates the entry, writes it back and loads the result register. The
// state memory's read is registered, so no new request is accepted until the
// sequencer is back in S_IDLE. A reading returns one result; a hook request
// returns none. The result register frees the request side while a result
// waits on out_ch; a request whose result finds that register still full holds
// in the update cycle until it drains. Channel state clears at reset through
// per-channel valid bits, so no clearing pass is needed. The user must write
// pot_max via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module pot_soft_takeover_core import pst_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    pst_in_if.sink               in_ch,
    pst_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [POT_MAX_W-1:0] cfg_wdata
);

    fsm_t                  state_reg;
    fsm_t                  state_next;
    logic [POT_MAX_W-1:0]  pot_max_reg;
    logic [CHANNELS-1:0]   valid_reg;
    pst_op_t               op_reg;
    logic [CH_IDX_W-1:0]   idx_reg;
    logic [VALUE_BITS-1:0] live_reg;
    logic [VALUE_BITS-1:0] hook_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_value_reg;

    logic                  accept;
    logic                  finish;
    logic                  slot_free;
    logic [CH_EXT_W-1:0]   ch_ext;
    logic [CH_IDX_W-1:0]   rd_idx;
    logic                  in_range_in;
    logic                  raw_gt;
    logic [POT_MAX_W-1:0]  diff;
    logic [WIDE_W-1:0]     live_wide;
    logic [WIDE_W-1:0]     hook_wide;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                ent_mem;
    entry_t                ent_cur;
    pst_upd_t              upd;
    logic                  ram_we;

    // Decode the incoming request
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign ch_ext      = CH_EXT_W'(in_ch.channel);
    assign rd_idx      = ch_ext[CH_IDX_W-1:0];
    assign in_range_in = (ch_ext < CH_EXT_W'(CHANNELS));

    // Invert the raw sample against full scale
    assign raw_gt    = (in_ch.raw_reading > RAW_W'(pot_max_reg));
    assign diff      = pot_max_reg - in_ch.raw_reading[POT_MAX_W-1:0];
    assign live_wide = raw_gt ? '0 : WIDE_W'(diff);
    assign hook_wide = WIDE_W'(in_ch.hook_value);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pot_max_reg <= POT_MAX_RESET;
        end
        else if (cfg_we)
        begin
            pot_max_reg <= cfg_wdata;
        end
    end

    // Capture the transaction at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg.is_hook  <= (in_ch.req_type == REQ_HOOK);
            op_reg.ok       <= in_ch.read_ok;
            op_reg.in_range <= in_range_in;
            idx_reg         <= rd_idx;
            live_reg        <= live_wide[VALUE_BITS-1:0];
            hook_reg        <= hook_wide[VALUE_BITS-1:0];
        end
    end

    // State memory, read at accept and written back in the update cycle
    pst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (upd.entry),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Never-written entries read as unhooked with zero held value
    assign ent_mem = ram_rdata;
    always_comb
    begin
        if (valid_reg[idx_reg])
        begin
            ent_cur = ent_mem;
        end
        else
        begin
            ent_cur.hook = HS_UNHOOKED;
            ent_cur.held = '0;
        end
    end

    pst_update u_update (
        .op   (op_reg),
        .cur  (ent_cur),
        .live (live_reg),
        .hook (hook_reg),
        .upd  (upd)
    );

    // Finish when the result register can take the result, or when there is no result
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign finish    = (state_reg == S_EXEC) && (!upd.has_result || slot_free);
    assign ram_we    = finish && upd.wr_en;

    // Mark channels written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish && upd.has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && upd.has_result)
        begin
            out_value_reg <= upd.result;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pot_value = out_value_reg;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance from read to update and back
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pst_checker.sv
// Port-level checks for the soft-takeover core, bound to the top level.
module pst_checker import pst_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] out_value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result changed while stalled");

    // One transaction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one is in update");

    // A fresh result follows an accepted request through the update state and the result register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching request");

endmodule

bind pot_soft_takeover_core pst_checker u_pst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.pot_value)
);
